// File: sv/bitmap_first_fit_allocator_core_defines.svh
// Assertion macros shared by the allocator RTL
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH

// Checked only outside reset
`define BFFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define BFFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/bffa_pkg.sv
// Types and constants of the bitmap first-fit allocator
`default_nettype none
package bffa_pkg;

  localparam int CELLS_DEF = 64;
  // wide enough for any cell index plus any run length
  localparam int SUM_W     = 8;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_BADINDEX = 2'd2;
  localparam logic [1:0] ST_ZERO     = 2'd3;

  typedef struct packed {
    logic       mode;
    logic [6:0] start_index;
    logic [6:0] run_length;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] granted_index;
    logic       compacted;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PACK,
    S_MARK,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: sv/bitmap_first_fit_allocator_core.sv
// Bitmap first-fit allocator: bit-serial scan, compaction and marking of the map
//
// Input channel (in_valid/in_stall/in_data) carries one request: allocate a
// run of run_length cells, or free a run from start_index. Output channel
// (out_valid/out_stall/out_data) returns one result per request.
// The map lives in a CELLS-bit circular shift register; each pass rotates it
// once, one cell per cycle.
// Steps from acceptance to the result, before it enters the output register:
//   Zero length or bad free index: no pass over the map.
//   Free: one marking pass.
//   Allocate, fit found: search pass plus marking pass.
//   Allocate, no fit: search pass plus a combined compact-and-mark pass.
// One request is in flight at a time; in_stall is high from acceptance until
// the result has been moved into the output register, and the next request
// can be taken in the cycle after that.
// A result waiting on a stalled output does not block acceptance of the next
// request; that request waits only at its own end if the register is still full.
// Reset (synchronous, rst_n low) frees every cell and drops out_valid.
`default_nettype none
module bitmap_first_fit_allocator_core
  import bffa_pkg::*;
#(
  parameter int CELLS = CELLS_DEF
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  wire  out_stall,
  output out_t out_data
);

`include "bitmap_first_fit_allocator_core_defines.svh"

  localparam int IW = $clog2(CELLS);
  localparam int CW = $clog2(CELLS + 1);

  state_t state_r, state_nxt;

  logic [CELLS-1:0] map_r, map_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    run_r, run_nxt;
  logic [IW-1:0]    first_r, first_nxt;
  logic             found_r, found_nxt;
  logic [IW-1:0]    start_r, start_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [6:0]       len_r, len_nxt;
  logic             mode_r, mode_nxt;
  out_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic             accept;
  logic             last_cell;
  logic             cur;
  logic [CW-1:0]    run_inc;
  logic [IW-1:0]    cand;
  logic             hit;
  logic             req_err;
  logic             load_out;
  logic [SUM_W-1:0] i_ext, lo_ext, hi_ext, used_ext, used_end;
  logic             fit, in_run, pack_bit;

  // shared datapath terms
  always_comb begin
    accept    = in_valid && !in_stall;
    last_cell = (idx_r == IW'(CELLS - 1));
    cur       = map_r[0];
    run_inc   = run_r + CW'(1);
    cand      = (run_r == '0) ? idx_r : first_r;
    hit       = !cur && (SUM_W'(run_inc) == SUM_W'(len_r));
    req_err   = (in_data.run_length == 7'd0) ||
                ((in_data.mode == MODE_FREE) &&
                 ({1'b0, in_data.start_index} >= SUM_W'(CELLS)));
    i_ext     = SUM_W'(idx_r);
    lo_ext    = SUM_W'(start_r);
    hi_ext    = lo_ext + SUM_W'(len_r);
    in_run    = (i_ext >= lo_ext) && (i_ext < hi_ext);
    used_ext  = SUM_W'(used_r);
    used_end  = used_ext + SUM_W'(len_r);
    fit       = (used_end <= SUM_W'(CELLS));
    pack_bit  = (i_ext < used_ext) || (fit && (i_ext < used_end));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_err) begin
            state_nxt = S_DONE;
          end else if (in_data.mode == MODE_ALLOC) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_MARK;
          end
        end
      end
      S_SCAN: begin
        if (last_cell) begin
          state_nxt = (found_r || hit) ? S_MARK : S_PACK;
        end
      end
      S_PACK: begin
        if (last_cell) begin
          state_nxt = S_DONE;
        end
      end
      S_MARK: begin
        if (last_cell) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_DONE:  load_out = !out_valid_r || !out_stall;
      default: begin
        in_stall = 1'b1;
        load_out = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    map_nxt   = map_r;
    idx_nxt   = idx_r;
    run_nxt   = run_r;
    first_nxt = first_r;
    found_nxt = found_r;
    start_nxt = start_r;
    used_nxt  = used_r;
    len_nxt   = len_r;
    mode_nxt  = mode_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          run_nxt   = '0;
          first_nxt = '0;
          found_nxt = 1'b0;
          used_nxt  = '0;
          start_nxt = IW'(in_data.start_index);
          len_nxt   = in_data.run_length;
          mode_nxt  = in_data.mode;
          res_nxt.status        = ST_OK;
          res_nxt.granted_index = '0;
          res_nxt.compacted     = 1'b0;
          if ((in_data.mode == MODE_FREE) &&
              ({1'b0, in_data.start_index} >= SUM_W'(CELLS))) begin
            res_nxt.status = ST_BADINDEX;
          end else if (in_data.run_length == 7'd0) begin
            res_nxt.status = ST_ZERO;
          end
        end
      end
      S_SCAN: begin
        map_nxt   = {cur, map_r[CELLS-1:1]};
        idx_nxt   = last_cell ? '0 : idx_r + IW'(1);
        run_nxt   = cur ? '0 : run_inc;
        first_nxt = cand;
        used_nxt  = used_r + CW'(cur);
        if (!found_r && hit) begin
          found_nxt = 1'b1;
          start_nxt = cand;
        end
      end
      S_PACK: begin
        // rebuild the map packed at the bottom, new run straight after it if it fits
        map_nxt = {pack_bit, map_r[CELLS-1:1]};
        idx_nxt = last_cell ? '0 : idx_r + IW'(1);
        if (last_cell) begin
          res_nxt.compacted     = 1'b1;
          res_nxt.status        = fit ? ST_OK : ST_NOSPACE;
          res_nxt.granted_index = fit ? 6'(used_r) : 6'd0;
        end
      end
      S_MARK: begin
        if (mode_r == MODE_ALLOC) begin
          map_nxt = {cur | in_run, map_r[CELLS-1:1]};
        end else begin
          map_nxt = {cur & !in_run, map_r[CELLS-1:1]};
        end
        idx_nxt = last_cell ? '0 : idx_r + IW'(1);
        if (last_cell && (mode_r == MODE_ALLOC)) begin
          res_nxt.granted_index = 6'(start_r);
        end
      end
      default: begin
        map_nxt = map_r;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      map_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_r       <= map_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r      <= run_nxt;
    first_r    <= first_nxt;
    found_r    <= found_nxt;
    start_r    <= start_nxt;
    used_r     <= used_nxt;
    len_r      <= len_nxt;
    mode_r     <= mode_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BFFA_ASSERT(a_accept_leaves_idle, (in_valid && !in_stall) |=> (state_r != S_IDLE), "transaction accepted but block stayed idle")
  `BFFA_ASSERT(a_idle_aligned, (state_r == S_IDLE) |-> (idx_r == '0), "map rotation misaligned in idle")
  `BFFA_ASSERT(a_nospace_compacted, (out_valid && (out_data.status == ST_NOSPACE)) |-> out_data.compacted, "allocation failed without compaction")
  `BFFA_ASSERT(a_result_from_done, $rose(out_valid) |-> ($past(state_r) == S_DONE), "result appeared outside completion")
  `BFFA_ASSERT_ALWAYS(a_reset_clears, (!rst_n) |=> (!out_valid && (map_r == '0)), "reset left a result or allocated cells")

endmodule
`default_nettype wire
